### rtl/core/first_fit_free_list_allocator_macros.svh
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator macros
// Assertion shorthands used by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH

// Check a condition in the same cycle as its trigger
`define FFA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger
`define FFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Types and constants shared by the free-list allocator and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

    // Field widths of the item payloads
    localparam int FIELD_W = 16;
    localparam int SIZE_W  = 16;
    localparam int NEED_W  = SIZE_W + 1;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 1;

    // Request kinds
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_SIZE = 1'b1;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STATUS_ALLOCATED = 2'd0,
        STATUS_NO_FIT    = 2'd1,
        STATUS_FREED     = 2'd2,
        STATUS_DROPPED   = 2'd3
    } t_status;

    // Per-cycle command to one list cell
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_COMPARE,
        CELL_SELECT,
        CELL_LOAD_LEFT,
        CELL_LOAD_RIGHT,
        CELL_SPLIT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     active;
    } t_cell_ctl;

endpackage

`default_nettype wire

### rtl/core/ffa_cell.sv
// ----------------------------------------------------------------------------
// ffa_cell
// One free-list entry: holds a block, compares it against the request, takes
// part in the first-fit chain and shifts or splits on command.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_cell #(
    parameter int ADDR_W = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ffa_pkg::t_cell_ctl         i_ctl,
    input  logic [ffa_pkg::NEED_W-1:0] i_need,
    input  logic [ADDR_W-1:0]          i_left_addr,
    input  logic [ffa_pkg::SIZE_W-1:0] i_left_size,
    input  logic [ADDR_W-1:0]          i_right_addr,
    input  logic [ffa_pkg::SIZE_W-1:0] i_right_size,
    input  logic                       i_found,
    input  logic [ADDR_W-1:0]          i_sel_addr,
    input  logic                       i_sel_exact,
    output logic [ADDR_W-1:0]          o_addr,
    output logic [ffa_pkg::SIZE_W-1:0] o_size,
    output logic                       o_found,
    output logic [ADDR_W-1:0]          o_sel_addr,
    output logic                       o_sel_exact,
    output logic                       o_hit
);

    logic [ADDR_W-1:0]          r_addr;
    logic [ffa_pkg::SIZE_W-1:0] r_size;
    logic                       r_lt;
    logic                       r_eq;
    logic                       r_hit;
    logic                       r_after;
    logic                       w_fit;
    logic                       w_hit;

    // First fitting cell wins; pass its block down the chain
    assign w_fit       = r_lt | r_eq;
    assign w_hit       = w_fit & ~i_found;
    assign o_found     = i_found | w_fit;
    assign o_sel_addr  = w_hit ? r_addr : i_sel_addr;
    assign o_sel_exact = w_hit ? r_eq : i_sel_exact;
    assign o_addr      = r_addr;
    assign o_size      = r_size;
    assign o_hit       = r_hit;

    // Compare and select flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt    <= 1'b0;
            r_eq    <= 1'b0;
            r_hit   <= 1'b0;
            r_after <= 1'b0;
        end else begin
            case (i_ctl.op)
                ffa_pkg::CELL_COMPARE: begin
                    r_lt <= i_ctl.active && (i_need < {1'b0, r_size});
                    r_eq <= i_ctl.active && (i_need == {1'b0, r_size});
                end
                ffa_pkg::CELL_SELECT: begin
                    r_hit   <= w_hit;
                    r_after <= o_found;
                end
                default: begin
                end
            endcase
        end
    end

    // Block contents: shift, split or hold
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            ffa_pkg::CELL_LOAD_LEFT: begin
                r_addr <= i_left_addr;
                r_size <= i_left_size;
            end
            ffa_pkg::CELL_LOAD_RIGHT: begin
                if (r_after) begin
                    r_addr <= i_right_addr;
                    r_size <= i_right_size;
                end
            end
            ffa_pkg::CELL_SPLIT: begin
                if (r_hit) begin
                    r_addr <= r_addr + ADDR_W'(i_need);
                    r_size <= r_size - i_need[ffa_pkg::SIZE_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/first_fit_free_list_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator
// First-fit heap allocator over a row of free-list cells.
// ----------------------------------------------------------------------------
// The free list lives in a row of MAX_FREE_BLOCKS cells, front at cell 0.
// The first item after reset seeds cell 0 with {heap_base, heap_size}; later
// register writes are not used by the list, and reset clears them. An
// allocate steps through accept, parallel compare in every cell, first-fit
// select along the cell chain, then split or shift-out, with its result
// registered in the last step; a free steps through accept, then a shift of
// the row right by one cell, with its result registered in that step. The
// next item is accepted in the cycle after the result is loaded into the
// output register, so a stalled output adds its stall cycles to the item in
// flight. Freed blocks are trusted as given and never merged; a free into a
// full list is dropped with status 3.
`default_nettype none

module first_fit_free_list_allocator #(
    parameter int MAX_FREE_BLOCKS = 16,
    parameter int HEADER_BYTES    = 4,
    parameter int ADDRESS_BITS    = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [ffa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ffa_pkg::FIELD_W-1:0]   i_cfg_data,
    // request items
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // [15:0] request_size, [31:16] block_address, [47:32] block_size
    input  logic [47:0]                   i_s_axis_tdata,
    // [0] opcode
    input  logic                          i_s_axis_tuser,
    // result items
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [15:0] data_address, [31:16] granted_size
    output logic [31:0]                   o_m_axis_tdata,
    // [1:0] status
    output logic [ffa_pkg::STAT_W-1:0]    o_m_axis_tuser
);

`include "first_fit_free_list_allocator_macros.svh"

    localparam int CNT_W = $clog2(MAX_FREE_BLOCKS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_SEL,
        ST_UPD
    } t_state;

    t_state                       r_state;
    logic                         r_seeded;
    logic [CNT_W-1:0]             r_count;
    logic [ffa_pkg::FIELD_W-1:0]  r_heap_base;
    logic [ffa_pkg::SIZE_W-1:0]   r_heap_size;
    logic                         r_op;
    logic [ffa_pkg::NEED_W-1:0]   r_need;
    logic [ffa_pkg::FIELD_W-1:0]  r_free_addr;
    logic [ffa_pkg::SIZE_W-1:0]   r_free_size;
    logic                         r_res_found;
    logic                         r_res_exact;
    logic [ffa_pkg::FIELD_W-1:0]  r_res_addr;
    logic                         r_out_valid;
    ffa_pkg::t_status             r_out_status;
    logic [ffa_pkg::FIELD_W-1:0]  r_out_addr;
    logic [ffa_pkg::SIZE_W-1:0]   r_out_size;

    logic                         w_in_accept;
    logic                         w_slot_free;
    logic                         w_full;
    logic                         w_update;
    logic [ADDRESS_BITS-1:0]      w_inject_addr;
    logic [ffa_pkg::SIZE_W-1:0]   w_inject_size;
    logic [ADDRESS_BITS-1:0]      w_grant_addr;
    logic [ffa_pkg::FIELD_W-1:0]  w_req_size;
    ffa_pkg::t_cell_ctl           w_ctl [MAX_FREE_BLOCKS];
    logic [ADDRESS_BITS-1:0]      w_cell_addr [MAX_FREE_BLOCKS];
    logic [ffa_pkg::SIZE_W-1:0]   w_cell_size [MAX_FREE_BLOCKS];
    logic [MAX_FREE_BLOCKS:0]     w_found;
    logic [ADDRESS_BITS-1:0]      w_sel_addr [MAX_FREE_BLOCKS+1];
    logic [MAX_FREE_BLOCKS:0]     w_sel_exact;
    logic [MAX_FREE_BLOCKS-1:0]   w_hits;

    // Handshakes and status
    assign w_in_accept     = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_slot_free     = !r_out_valid || i_m_axis_tready;
    assign w_full          = (r_count == CNT_W'(MAX_FREE_BLOCKS));
    assign w_update        = (r_state == ST_UPD) && w_slot_free;
    assign w_req_size      = i_s_axis_tdata[15:0];

    // Entry pushed into the front cell: seed block, or freed block
    always_comb begin
        if (!r_seeded) begin
            w_inject_addr = ADDRESS_BITS'(r_heap_base);
            w_inject_size = r_heap_size;
        end else begin
            w_inject_addr = ADDRESS_BITS'(r_free_addr) - ADDRESS_BITS'(HEADER_BYTES);
            w_inject_size = r_free_size;
        end
    end

    // Drive one command per cell
    always_comb begin
        for (int i = 0; i < MAX_FREE_BLOCKS; i++) begin
            w_ctl[i].active = (r_count > CNT_W'(i));
            w_ctl[i].op     = ffa_pkg::CELL_HOLD;
            case (r_state)
                ST_IDLE: begin
                    if (w_in_accept && !r_seeded && i == 0) begin
                        w_ctl[i].op = ffa_pkg::CELL_LOAD_LEFT;
                    end
                end
                ST_CMP:  w_ctl[i].op = ffa_pkg::CELL_COMPARE;
                ST_SEL:  w_ctl[i].op = ffa_pkg::CELL_SELECT;
                ST_UPD: begin
                    if (w_update) begin
                        if (r_op == ffa_pkg::OP_FREE) begin
                            if (!w_full) begin
                                w_ctl[i].op = ffa_pkg::CELL_LOAD_LEFT;
                            end
                        end else if (r_res_found) begin
                            w_ctl[i].op = r_res_exact ? ffa_pkg::CELL_LOAD_RIGHT
                                                      : ffa_pkg::CELL_SPLIT;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Row of list cells
    assign w_found[0]     = 1'b0;
    assign w_sel_addr[0]  = '0;
    assign w_sel_exact[0] = 1'b0;

    for (genvar g = 0; g < MAX_FREE_BLOCKS; g++) begin : g_cell
        logic [ADDRESS_BITS-1:0]    w_left_addr;
        logic [ffa_pkg::SIZE_W-1:0] w_left_size;
        logic [ADDRESS_BITS-1:0]    w_right_addr;
        logic [ffa_pkg::SIZE_W-1:0] w_right_size;

        if (g == 0) begin : g_front
            assign w_left_addr = w_inject_addr;
            assign w_left_size = w_inject_size;
        end else begin : g_inner
            assign w_left_addr = w_cell_addr[g-1];
            assign w_left_size = w_cell_size[g-1];
        end

        if (g == MAX_FREE_BLOCKS - 1) begin : g_back
            assign w_right_addr = '0;
            assign w_right_size = '0;
        end else begin : g_mid
            assign w_right_addr = w_cell_addr[g+1];
            assign w_right_size = w_cell_size[g+1];
        end

        ffa_cell #(
            .ADDR_W (ADDRESS_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl[g]),
            .i_need       (r_need),
            .i_left_addr  (w_left_addr),
            .i_left_size  (w_left_size),
            .i_right_addr (w_right_addr),
            .i_right_size (w_right_size),
            .i_found      (w_found[g]),
            .i_sel_addr   (w_sel_addr[g]),
            .i_sel_exact  (w_sel_exact[g]),
            .o_addr       (w_cell_addr[g]),
            .o_size       (w_cell_size[g]),
            .o_found      (w_found[g+1]),
            .o_sel_addr   (w_sel_addr[g+1]),
            .o_sel_exact  (w_sel_exact[g+1]),
            .o_hit        (w_hits[g])
        );
    end

    // Data address of the selected block, past its header
    assign w_grant_addr = w_sel_addr[MAX_FREE_BLOCKS] + ADDRESS_BITS'(HEADER_BYTES);

    // Sequencer, list count, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seeded    <= 1'b0;
            r_count     <= '0;
            r_heap_base <= '0;
            r_heap_size <= '0;
            r_out_valid <= 1'b0;
            r_res_found <= 1'b0;
            r_res_exact <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ffa_pkg::CFG_HEAP_BASE: r_heap_base <= i_cfg_data;
                    ffa_pkg::CFG_HEAP_SIZE: r_heap_size <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // Drop the result once taken, unless a new one replaces it
            if (r_out_valid && i_m_axis_tready && !w_update) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_in_accept) begin
                        r_op        <= i_s_axis_tuser;
                        r_need      <= ffa_pkg::NEED_W'(w_req_size)
                                       + ffa_pkg::NEED_W'(HEADER_BYTES);
                        r_free_addr <= i_s_axis_tdata[31:16];
                        r_free_size <= i_s_axis_tdata[47:32];
                        if (!r_seeded) begin
                            r_seeded <= 1'b1;
                            r_count  <= CNT_W'(1);
                        end
                        r_state <= (i_s_axis_tuser == ffa_pkg::OP_FREE) ? ST_UPD : ST_CMP;
                    end
                end
                ST_CMP: begin
                    r_state <= ST_SEL;
                end
                ST_SEL: begin
                    r_res_found <= w_found[MAX_FREE_BLOCKS];
                    r_res_exact <= w_sel_exact[MAX_FREE_BLOCKS];
                    r_res_addr  <= ffa_pkg::FIELD_W'(w_grant_addr);
                    r_state     <= ST_UPD;
                end
                ST_UPD: begin
                    if (w_slot_free) begin
                        r_out_valid <= 1'b1;
                        if (r_op == ffa_pkg::OP_FREE) begin
                            r_out_addr <= '0;
                            r_out_size <= '0;
                            if (w_full) begin
                                r_out_status <= ffa_pkg::STATUS_DROPPED;
                            end else begin
                                r_out_status <= ffa_pkg::STATUS_FREED;
                                r_count      <= r_count + CNT_W'(1);
                            end
                        end else if (r_res_found) begin
                            r_out_status <= ffa_pkg::STATUS_ALLOCATED;
                            r_out_addr   <= r_res_addr;
                            r_out_size   <= r_need[ffa_pkg::SIZE_W-1:0];
                            if (r_res_exact) begin
                                r_count <= r_count - CNT_W'(1);
                            end
                        end else begin
                            r_out_status <= ffa_pkg::STATUS_NO_FIT;
                            r_out_addr   <= '0;
                            r_out_size   <= '0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Result port
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_size, r_out_addr};
    assign o_m_axis_tuser  = r_out_status;

    // List never holds more entries than cells
    `FFA_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= CNT_W'(MAX_FREE_BLOCKS), "free count above list depth")
    // At most one cell claims the first fit
    `FFA_ASSERT_NOW(a_single_hit, i_clk, i_rst_n, 1'b1,
        $onehot0(w_hits), "more than one cell selected")
    // An accepted free into a non-full list grows the list by one
    `FFA_ASSERT_NEXT(a_free_grows, i_clk, i_rst_n,
        w_update && r_op == ffa_pkg::OP_FREE && !w_full,
        r_count == $past(r_count) + CNT_W'(1), "free did not grow the list")

endmodule

`default_nettype wire
